/* rtl/pidl_pkg.sv */
// ----------------------------------------------------------------------------
// pidl_pkg
// Shared types and constants for the positional insert/delete list: action
// and status codes, word layouts and the command that drives the cell chain.
// ----------------------------------------------------------------------------
package pidl_pkg;

  // Number of entries the list can hold.
  localparam int CAPACITY = 16;

  // Field widths.
  localparam int DATA_W = 32;
  localparam int POS_W  = 5;
  localparam int CNT_W  = 5;
  localparam int IDX_W  = $clog2(CAPACITY);

  // Count value that means the list is full.
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // Action codes.
  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_DELETE = 2'd2;
  localparam logic [1:0] ACT_READ   = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  // Input word.
  typedef struct packed {
    logic [1:0]               action;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] element;
    logic [CNT_W-1:0]         count;
  } out_word_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic               shift_up;
    logic               shift_down;
    logic [POS_W-1:0]   pos;
    logic [DATA_W-1:0]  value;
  } cell_cmd_t;

endpackage

/* rtl/pidl_cell.sv */
// ----------------------------------------------------------------------------
// pidl_cell
// One list entry. On an insert it takes the new value or its lower
// neighbor's entry; on a delete it takes its upper neighbor's entry.
// ----------------------------------------------------------------------------
module pidl_cell
  import pidl_pkg::*;
(
  input  logic              clk,
  input  logic [POS_W-1:0]  idx,
  input  cell_cmd_t         cmd,
  input  logic [DATA_W-1:0] lower_data,
  input  logic [DATA_W-1:0] upper_data,
  output logic [DATA_W-1:0] data
);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;

  // Pick the next entry from the command and this cell's place in the row.
  always_comb begin
    data_nxt = data_r;
    if (cmd.shift_up) begin
      if (idx == cmd.pos) begin
        data_nxt = cmd.value;
      end else if (idx > cmd.pos) begin
        data_nxt = lower_data;
      end
    end else if (cmd.shift_down) begin
      if (idx >= cmd.pos) begin
        data_nxt = upper_data;
      end
    end
  end

  // Entry register; its contents are undefined until written.
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

/* rtl/positional_insert_delete_list_top.sv */
// A result word is registered and appears in the cycle after its input word is accepted.
// One word is taken per cycle while the output is not stalled; every cell of the chain shifts in parallel.
// A new word is taken whenever the output register is empty or being drained.
// Reset (rst_n low, synchronous) empties the list and the output register;
// the entry cells are not cleared, since only entries below the count are read.
// ----------------------------------------------------------------------------
// positional_insert_delete_list_top
// Bounded ordered list of signed words held in a row of cells, with clear,
// insert, delete and read at a position, each returning one status word.
// ----------------------------------------------------------------------------
module positional_insert_delete_list_top
  import pidl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  out_word_t         out_word_r;
  out_word_t         out_word_nxt;
  logic              accept;
  logic              is_full;
  logic              is_empty;
  logic              ins_ok;
  logic              rd_ok;
  cell_cmd_t         cmd;
  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [DATA_W-1:0] sel_data;

  // Take a word when the output register is free or drains this cycle.
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  // Legality of the requested action against the current count.
  assign is_full  = (count_r == CAP_CNT);
  assign is_empty = (count_r == '0);
  assign ins_ok   = ~is_full & (in_word.position <= count_r);
  assign rd_ok    = ~is_empty & (in_word.position < count_r);

  // Entry at the requested position, valid only when it lies below the count.
  assign sel_data = cell_data[in_word.position[IDX_W-1:0]];

  // Command broadcast to the cells.
  always_comb begin
    cmd.shift_up   = accept & (in_word.action == ACT_INSERT) & ins_ok;
    cmd.shift_down = accept & (in_word.action == ACT_DELETE) & rd_ok;
    cmd.pos        = in_word.position;
    cmd.value      = in_word.value;
  end

  // Chain of cells; the ends see zero from outside the row.
  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic [DATA_W-1:0] lower_d;
      logic [DATA_W-1:0] upper_d;
      if (g == 0) begin : g_first
        assign lower_d = '0;
      end else begin : g_lower
        assign lower_d = cell_data[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign upper_d = '0;
      end else begin : g_upper
        assign upper_d = cell_data[g+1];
      end
      pidl_cell u_cell (
        .clk        (clk),
        .idx        (POS_W'(g)),
        .cmd        (cmd),
        .lower_data (lower_d),
        .upper_data (upper_d),
        .data       (cell_data[g])
      );
    end
  endgenerate

  // Status, element and new count for the accepted word.
  always_comb begin
    count_nxt            = count_r;
    out_word_nxt.status  = ST_OK;
    out_word_nxt.element = '0;
    case (in_word.action)
      ACT_CLEAR: begin
        count_nxt = '0;
      end
      ACT_INSERT: begin
        if (is_full) begin
          out_word_nxt.status = ST_FULL;
        end else if (!ins_ok) begin
          out_word_nxt.status = ST_RANGE;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      ACT_DELETE, ACT_READ: begin
        if (is_empty) begin
          out_word_nxt.status = ST_EMPTY;
        end else if (!rd_ok) begin
          out_word_nxt.status = ST_RANGE;
        end else begin
          out_word_nxt.element = sel_data;
          if (in_word.action == ACT_DELETE) begin
            count_nxt = count_r - CNT_W'(1);
          end
        end
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
    out_word_nxt.count = count_nxt;
  end

  // Output register handshake.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

/* rtl/pidl_checker.sv */
// ----------------------------------------------------------------------------
// pidl_checker
// Port-level checks for the positional insert/delete list, bound to the top.
// ----------------------------------------------------------------------------
module pidl_checker
  import pidl_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_word_t  in_word,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_word
);

  // A stalled result word stays on the port.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // The reported count never exceeds the capacity.
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.count <= CAP_CNT)
    else $error("count above capacity");

  // A full refusal reports a full list.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status == ST_FULL |-> out_word.count == CAP_CNT)
    else $error("full status with count below capacity");

  // Refused actions return a zero element and an empty refusal a zero count.
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status != ST_OK |-> out_word.element == '0 &&
      (out_word.status != ST_EMPTY || out_word.count == '0))
    else $error("refused action returned data");

  // An accepted clear gives an ok word with zero count in the next cycle.
  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_word.action == ACT_CLEAR |=>
      out_valid && out_word.status == ST_OK && out_word.count == '0)
    else $error("clear did not empty the list");

endmodule

bind positional_insert_delete_list_top pidl_checker u_pidl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the positional insert/delete list. Words are driven
// through the valid/stall handshake with random idle bursts on both sides. A
// scoreboard keeps its own copy of the list, predicts the status, element
// and count for each accepted word, and compares them with each result word.
// ----------------------------------------------------------------------------
module testbench;
  import pidl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_WORDS   = 1700;
  localparam int SEGMENT_WORDS  = 100;

  // Scoreboard: shadow list plus the queue of result words still owed.
  class list_scoreboard;
    logic signed [DATA_W-1:0] entries [CAPACITY];
    int unsigned              held;
    out_word_t                owed_q[$];
    int                       mismatches;

    function new();
      held       = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    // Apply one accepted word to the shadow list and queue its result.
    function void note_word(in_word_t w);
      out_word_t   r;
      int unsigned p;
      r        = '0;
      r.status = ST_OK;
      p        = w.position;
      case (w.action)
        ACT_CLEAR: begin
          held = 0;
        end
        ACT_INSERT: begin
          if (held >= CAPACITY) begin
            r.status = ST_FULL;
          end else if (p > held) begin
            r.status = ST_RANGE;
          end else begin
            for (int i = held; i > p; i--) entries[i] = entries[i-1];
            entries[p] = w.value;
            held++;
          end
        end
        default: begin
          // Delete and read share the emptiness and range checks.
          if (held == 0) begin
            r.status = ST_EMPTY;
          end else if (p >= held) begin
            r.status = ST_RANGE;
          end else begin
            r.element = entries[p];
            if (w.action == ACT_DELETE) begin
              for (int i = p; i + 1 < held; i++) entries[i] = entries[i+1];
              held--;
            end
          end
        end
      endcase
      r.count = CNT_W'(held);
      owed_q.push_back(r);
    endfunction

    // Compare one result word with the oldest prediction.
    task check_word(out_word_t got);
      out_word_t want;
      if (owed_q.size() == 0) begin
        report($sformatf("result with nothing owed: status %0d element %h count %0d",
                         got.status, got.element, got.count));
        return;
      end
      want = owed_q.pop_front();
      if (got.status !== want.status)
        report($sformatf("status %0d, predicted %0d", got.status, want.status));
      if (got.element !== want.element)
        report($sformatf("element %h, predicted %h", got.element, want.element));
      if (got.count !== want.count)
        report($sformatf("count %0d, predicted %0d", got.count, want.count));
    endtask
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  list_scoreboard sb;
  bit             idle_on = 1'b1;
  bit             growing = 1'b1;
  int             stall_left = 0;
  int             quiet_cycles = 0;

  positional_insert_delete_list_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always #5 clk = ~clk;

  // Result side stalls in random bursts while idling is on.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 16);
    end
    out_stall <= (stall_left > 0);
  end

  // Check every accepted result word.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_word(out_word);
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("positional_insert_delete_list_top test failed");
      $finish;
    end
  end

  // Offer one word, with an optional idle burst first, and wait until taken.
  task automatic send_word(input logic [1:0] act, input int unsigned p,
                           input logic [DATA_W-1:0] v);
    in_word_t w;
    w.action   = act;
    w.position = POS_W'(p);
    w.value    = v;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(w);
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return DATA_W'($urandom_range(0, 20));
      3:       return -DATA_W'($urandom_range(1, 20));
      default: return $urandom;
    endcase
  endfunction

  // Directed words: empty, range and full corners, then a clear.
  task automatic run_directed();
    int unsigned p;
    logic [DATA_W-1:0] v;
    send_word(ACT_READ, 0, '0);
    send_word(ACT_DELETE, 31, '1);
    send_word(ACT_INSERT, 1, 32'd5);
    // Fill the list at the front, at the end and in the middle.
    for (int k = 0; k < CAPACITY; k++) begin
      if (k % 3 == 0) p = 0;
      else if (k % 3 == 1) p = k;
      else p = k / 2;
      case (k)
        0:       v = 32'h7fff_ffff;
        1:       v = 32'h8000_0000;
        2:       v = '0;
        3:       v = '1;
        default: v = $urandom;
      endcase
      send_word(ACT_INSERT, p, v);
    end
    send_word(ACT_INSERT, CAPACITY, $urandom);
    send_word(ACT_INSERT, 31, $urandom);
    send_word(ACT_READ, CAPACITY - 1, '1);
    send_word(ACT_READ, CAPACITY, '0);
    send_word(ACT_DELETE, 0, '0);
    send_word(ACT_DELETE, CAPACITY - 2, '0);
    send_word(ACT_CLEAR, 31, '1);
    send_word(ACT_READ, 0, '0);
  endtask

  // Random word that mostly targets a valid position and walks the level
  // between empty and full.
  task automatic send_random();
    logic [1:0]  act;
    int unsigned p;
    int unsigned lvl;
    int unsigned roll;
    lvl = sb.held;
    if (lvl >= CAPACITY) growing = 1'b0;
    else if (lvl == 0) growing = 1'b1;
    else if ($urandom_range(0, 39) == 0) growing = !growing;
    roll = $urandom_range(0, 99);
    if (roll < 2) act = ACT_CLEAR;
    else if (roll < (growing ? 62 : 30)) act = ACT_INSERT;
    else if (roll < 80) act = ACT_DELETE;
    else act = ACT_READ;
    if ($urandom_range(0, 9) == 0) p = $urandom_range(0, 31);
    else if (act == ACT_INSERT) p = $urandom_range(0, lvl);
    else if (lvl == 0) p = 0;
    else p = $urandom_range(0, lvl - 1);
    send_word(act, p, pick_value());
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    // Random words in segments; the last two run without idling.
    for (int seg = 0; seg < RANDOM_WORDS / SEGMENT_WORDS; seg++) begin
      idle_on = (seg < RANDOM_WORDS / SEGMENT_WORDS - 2) && ($urandom_range(0, 3) != 0);
      repeat (SEGMENT_WORDS) send_random();
    end
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.pending() != 0) sb.report("predicted results never arrived");
    if (sb.mismatches == 0) begin
      $display("positional_insert_delete_list_top test passed");
    end else begin
      $display("positional_insert_delete_list_top test failed");
    end
    $finish;
  end

endmodule

/* positional_insert_delete_list_top.f */
rtl/pidl_pkg.sv
rtl/pidl_cell.sv
rtl/positional_insert_delete_list_top.sv
rtl/pidl_checker.sv
sim/testbench.sv
